// File: sv/ecf_pkg.sv
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared types, sizes and helpers for the edge interval capture FIFO.
// ----------------------------------------------------------------------------
package ecf_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = 16;
  localparam int WAIT_W     = 4;

  localparam logic ACT_CAPTURE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic             action;
    logic [CNT_W-1:0] capture_value;
  } in_t;

  typedef struct packed {
    logic              read_valid;
    logic [CNT_W-1:0]  interval;
    logic [WAIT_W-1:0] waiting_count;
    logic [CNT_W-1:0]  overflow_count;
    logic              edge_polarity;
  } out_t;

  // Advance a ring index, wrapping at the last slot.
  function automatic idx_t ring_next(input idx_t idx);
    ring_next = (idx == idx_t'(RING_DEPTH - 1)) ? '0 : idx + idx_t'(1);
  endfunction

  // Number of waiting intervals, masked to the report width.
  function automatic logic [WAIT_W-1:0] ring_waiting(input idx_t wr, input idx_t rd);
    logic [IDX_W:0] diff;
    diff = (wr >= rd) ? ({1'b0, wr} - {1'b0, rd})
                      : ({1'b0, wr} + (IDX_W+1)'(RING_DEPTH) - {1'b0, rd});
    ring_waiting = WAIT_W'(diff);
  endfunction

endpackage

// File: sv/ecf_ram.sv
// ----------------------------------------------------------------------------
// ecf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ecf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/edge_interval_capture_fifo.sv
// ----------------------------------------------------------------------------
// edge_interval_capture_fifo
// Timer input capture front end that queues intervals between edges.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the request is taken at a clock edge
//   where start is high and busy is low. in_item.action selects a capture
//   (timer count latched at an input edge) or a read of the oldest interval.
//   Every request yields exactly one result on out_item, marked by out_valid
//   for one cycle. The receiver cannot stall; the result must be taken then.
// Result timing:
//   A capture, or a read on an empty ring, returns its result in the cycle
//   after acceptance and a new request may follow in the very next cycle.
//   A read that pops an interval goes through the RAM: the interval ring sits
//   in a synchronous RAM, so the RAM read data is registered first (ST_READ,
//   busy is high) and the result is then registered from that read data.
// Reset:
//   Synchronous, active low. Clears the indices, the previous capture, the
//   overflow count and sets the expected polarity to falling. Ring contents
//   are not cleared; only slots written by a capture are ever popped.
// ----------------------------------------------------------------------------
module edge_interval_capture_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ecf_pkg::in_t  in_item,
  output logic          out_valid,
  output ecf_pkg::out_t out_item
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r, state_nxt;
  ecf_pkg::idx_t rd_idx_r, rd_idx_nxt;
  ecf_pkg::idx_t wr_idx_r, wr_idx_nxt;
  logic [ecf_pkg::CNT_W-1:0] prev_cap_r, prev_cap_nxt;
  logic [ecf_pkg::CNT_W-1:0] drop_cnt_r, drop_cnt_nxt;
  logic polarity_r, polarity_nxt;
  logic out_valid_r, out_valid_nxt;
  ecf_pkg::out_t out_item_r, out_item_nxt;

  logic accept;
  logic ram_we;
  logic [ecf_pkg::CNT_W-1:0] ram_wdata;
  logic [ecf_pkg::CNT_W-1:0] ram_rdata;
  ecf_pkg::idx_t wr_next;

  assign busy   = (state_r == ST_READ);
  assign accept = start && !busy;

  // The ring write always lands at the write index; when the ring is full
  // that is the spare slot, which is never popped.
  assign ram_we    = accept && (in_item.action == ecf_pkg::ACT_CAPTURE);
  assign ram_wdata = in_item.capture_value - prev_cap_r;
  assign wr_next   = ecf_pkg::ring_next(wr_idx_r);

  ecf_ram #(
    .WIDTH(ecf_pkg::CNT_W),
    .DEPTH(ecf_pkg::RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata(ram_wdata),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    prev_cap_nxt  = prev_cap_r;
    drop_cnt_nxt  = drop_cnt_r;
    polarity_nxt  = polarity_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.action == ecf_pkg::ACT_CAPTURE) begin
            // Toggle polarity, push or drop the interval, report at once.
            polarity_nxt = ~polarity_r;
            prev_cap_nxt = in_item.capture_value;
            if (wr_next == rd_idx_r) begin
              drop_cnt_nxt = drop_cnt_r + ecf_pkg::CNT_W'(1);
            end else begin
              wr_idx_nxt = wr_next;
            end
            out_valid_nxt              = 1'b1;
            out_item_nxt.read_valid    = 1'b0;
            out_item_nxt.interval      = '0;
            out_item_nxt.waiting_count = ecf_pkg::ring_waiting(wr_idx_nxt, rd_idx_r);
            out_item_nxt.overflow_count = drop_cnt_nxt;
            out_item_nxt.edge_polarity = polarity_nxt;
          end else if (rd_idx_r != wr_idx_r) begin
            // RAM read of the oldest slot is under way; pop and wait in ST_READ.
            rd_idx_nxt = ecf_pkg::ring_next(rd_idx_r);
            state_nxt  = ST_READ;
          end else begin
            // Empty ring: nothing to pop.
            out_valid_nxt              = 1'b1;
            out_item_nxt.read_valid    = 1'b0;
            out_item_nxt.interval      = '0;
            out_item_nxt.waiting_count = ecf_pkg::ring_waiting(wr_idx_r, rd_idx_r);
            out_item_nxt.overflow_count = drop_cnt_r;
            out_item_nxt.edge_polarity = polarity_r;
          end
        end
      end
      ST_READ: begin
        // Read data is back; indices already advanced.
        out_valid_nxt              = 1'b1;
        out_item_nxt.read_valid    = 1'b1;
        out_item_nxt.interval      = ram_rdata;
        out_item_nxt.waiting_count = ecf_pkg::ring_waiting(wr_idx_r, rd_idx_r);
        out_item_nxt.overflow_count = drop_cnt_r;
        out_item_nxt.edge_polarity = polarity_r;
        state_nxt                  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      prev_cap_r  <= '0;
      drop_cnt_r  <= '0;
      polarity_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      prev_cap_r  <= prev_cap_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      polarity_r  <= polarity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A popping read holds busy for exactly one cycle.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // A valid pop is reported only right after the RAM read cycle.
  a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.read_valid) |-> $past(state_r == ST_READ))
    else $error("popped result without a preceding RAM read");

  // Every accepted capture or empty-ring read is followed by a registered strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !(in_item.action == ecf_pkg::ACT_READ && rd_idx_r != wr_idx_r))
      |=> out_valid)
    else $error("missing result after request");

  // ring_next always moves the write index to another slot, unless the ring has a single slot.
  a_spare_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ecf_pkg::ring_next(wr_idx_r) != wr_idx_r || ecf_pkg::RING_DEPTH == 1)
    else $error("write index stuck");

endmodule

// File: bench/ecf_interval_bench_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecf_interval_bench_pkg
// Interval scoreboard for the edge interval capture FIFO bench.
// ----------------------------------------------------------------------------
package ecf_interval_bench_pkg;
  import ecf_pkg::*;

  class interval_scoreboard;
    logic [CNT_W-1:0] ring_copy [RING_DEPTH];
    logic [CNT_W-1:0] last_capture;
    logic [CNT_W-1:0] drop_total;
    int               rd_slot;
    int               wr_slot;
    logic             expect_falling;
    out_t             pending_results [$];
    int               mismatches;

    function new();
      foreach (ring_copy[i]) ring_copy[i] = '0;
      last_capture   = '0;
      drop_total     = '0;
      rd_slot        = 0;
      wr_slot        = 0;
      expect_falling = 1'b1;
      mismatches     = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the shadow ring by one accepted request and queue its result.
    function void note_request(in_t req);
      out_t want;
      want = '0;
      if (req.action == ACT_CAPTURE) begin
        expect_falling = ~expect_falling;
        // full ring: the difference only lands in the spare slot
        ring_copy[wr_slot] = req.capture_value - last_capture;
        last_capture = req.capture_value;
        if ((wr_slot + 1) % RING_DEPTH == rd_slot) begin
          drop_total = drop_total + 1'b1;
        end else begin
          wr_slot = (wr_slot + 1) % RING_DEPTH;
        end
      end else if (rd_slot != wr_slot) begin
        want.read_valid = 1'b1;
        want.interval   = ring_copy[rd_slot];
        rd_slot = (rd_slot + 1) % RING_DEPTH;
      end
      want.waiting_count  = WAIT_W'((wr_slot + RING_DEPTH - rd_slot) % RING_DEPTH);
      want.overflow_count = drop_total;
      want.edge_polarity  = expect_falling;
      pending_results.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = pending_results.pop_front();
      compare_field("read_valid", CNT_W'(got.read_valid), CNT_W'(want.read_valid));
      compare_field("interval", got.interval, want.interval);
      compare_field("waiting_count", CNT_W'(got.waiting_count), CNT_W'(want.waiting_count));
      compare_field("overflow_count", got.overflow_count, want.overflow_count);
      compare_field("edge_polarity", CNT_W'(got.edge_polarity), CNT_W'(want.edge_polarity));
    endtask

    task close_out();
      if (pending_results.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end
    endtask
  endclass

endpackage

// File: bench/edge_interval_capture_fifo_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_interval_capture_fifo_test
// Self-checking bench for the edge interval capture FIFO.
// ----------------------------------------------------------------------------
// Drives capture and read requests through the start/busy handshake and
// checks every strobed result against a shadow ring kept by the scoreboard.
// A short directed run covers an empty read, extreme and wrapping capture
// values, a full ring with dropped captures and refills. Random blocks then
// swing the capture/read mix so the ring fills and drains repeatedly, with
// bursty request timing. A final run of reads drains what is left.
// ----------------------------------------------------------------------------
module edge_interval_capture_fifo_test;
  import ecf_pkg::*;
  import ecf_interval_bench_pkg::*;

  localparam int CYCLE_LIMIT = 20000;

  logic  clk     = 1'b0;
  logic  rst_n   = 1'b0;
  logic  start   = 1'b0;
  in_t   in_item = '0;
  logic  busy;
  logic  out_valid;
  out_t  out_item;

  interval_scoreboard book = new();
  int unsigned        cycle_count = 0;
  int                 burst_left  = 0;
  logic [CNT_W-1:0]   timer_now   = '0;

  always #10 clk = ~clk;

  edge_interval_capture_fifo uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Bound the run; a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Take every strobed result; the receiver has no way to stall the block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        book.check_result(out_item);
      end else if (out_valid !== 1'b0) begin
        book.report_mismatch("out_valid is unknown");
      end
    end
  end

  // Present one request and hold it until an edge sees start high, busy low.
  // Leave start high afterwards so the next request can follow back to back.
  task automatic push_request(input logic act, input logic [CNT_W-1:0] value);
    in_t req;
    req.action        = act;
    req.capture_value = value;
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    book.note_request(req);
    if (act == ACT_CAPTURE) timer_now = value;
  endtask

  // Drop start for the given number of cycles.
  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Count down the current burst; at its end insert a gap and pick the next
  // burst length, now and then a long one so stretches run without idling.
  task automatic burst_step();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_sender($urandom_range(1, 5));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Pick a capture count: often a timer moving forward by a plausible
  // interval, sometimes a repeat (zero interval), a step back, extremes or pure noise.
  function automatic logic [CNT_W-1:0] next_stamp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: next_stamp = timer_now + CNT_W'($urandom_range(1, 400));
      4:          next_stamp = timer_now;
      5:          next_stamp = timer_now - CNT_W'($urandom_range(1, 50));
      6:          next_stamp = $urandom_range(0, 1) ? '1 : '0;
      default:    next_stamp = CNT_W'($urandom);
    endcase
  endfunction

  initial begin
    int capture_pct;
    int pct_pick;

    // Reset once at the start.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: read on an empty ring, then extreme and wrapping intervals.
    push_request(ACT_READ, 16'hFFFF);
    push_request(ACT_CAPTURE, 16'h0000);
    push_request(ACT_CAPTURE, 16'hFFFF);
    push_request(ACT_CAPTURE, 16'h0001);
    push_request(ACT_CAPTURE, 16'h8000);
    push_request(ACT_CAPTURE, 16'h7FFF);
    // Fill past capacity: fifteen intervals stored, the rest dropped.
    for (int i = 1; i <= 12; i++) begin
      push_request(ACT_CAPTURE, CNT_W'(i * 16'h1357));
    end
    // Pop two, refill one freed slot, pop the oldest again.
    push_request(ACT_READ, 16'h0000);
    push_request(ACT_READ, 16'h5555);
    push_request(ACT_CAPTURE, 16'hAAAA);
    push_request(ACT_READ, 16'h0000);
    drain_results();

    // Random blocks; swing the capture share so the ring fills and empties.
    for (int blk = 0; blk < 13; blk++) begin
      pct_pick = $urandom_range(0, 4);
      case (pct_pick)
        0:       capture_pct = 10;
        1:       capture_pct = 35;
        2:       capture_pct = 50;
        3:       capture_pct = 65;
        default: capture_pct = 92;
      endcase
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(0, 99) < capture_pct) begin
          push_request(ACT_CAPTURE, next_stamp());
        end else begin
          push_request(ACT_READ, CNT_W'($urandom));
        end
        burst_step();
      end
      // Hold off once mid-run until the block has answered everything.
      if (blk == 6) drain_results();
    end

    // Drain the ring with a last run of reads.
    for (int n = 0; n < 20; n++) begin
      push_request(ACT_READ, CNT_W'($urandom));
      burst_step();
    end

    // Wait out the last results, then idle on to catch any stray strobe before judging.
    start <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    book.close_out();
    if (book.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ecf_pkg.sv
sv/ecf_ram.sv
sv/edge_interval_capture_fifo.sv
bench/ecf_interval_bench_pkg.sv
bench/edge_interval_capture_fifo_test.sv
